FILE: design/c8alu_pkg.sv
// ----------------------------------------------------------------------------
// c8alu_pkg
// Shared types and operation codes of the 8-bit CPU ALU.
// ----------------------------------------------------------------------------
package c8alu_pkg;

    localparam int unsigned CMD_W  = 5;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 3;

    // Widths of the input and output transfers.
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 24;

    // DAA correction constants.
    localparam logic [BYTE_W-1:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [BYTE_W-1:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [3:0]        DAA_LO_LIMIT = 4'h9;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RRC   = 5'd11,
        OP_RL    = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SWAP  = 5'd16,
        OP_SRL   = 5'd17,
        OP_RLCA  = 5'd18,
        OP_RRCA  = 5'd19,
        OP_RLA   = 5'd20,
        OP_RRA   = 5'd21,
        OP_BIT   = 5'd22,
        OP_RES   = 5'd23,
        OP_SET   = 5'd24,
        OP_DAA   = 5'd25,
        OP_CPL   = 5'd26,
        OP_SCF   = 5'd27,
        OP_CCF   = 5'd28,
        OP_ADD16 = 5'd29,
        OP_ADDSP = 5'd30
    } alu_cmd_t;

    // Shift unit selector, shared by the prefixed and accumulator forms.
    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } shift_op_t;

    typedef struct packed {
        logic zero;
        logic sub;
        logic half;
        logic carry;
    } flags_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [IDX_W-1:0]  bit_index;
        flags_t            flags;
    } alu_req_t;

endpackage

FILE: design/cpu_8bit_alu_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags
// Stream-wrapped 8-bit CPU ALU with an input register and a result register.
// ----------------------------------------------------------------------------
// An input transfer loads the input register; a move then registers the ALU
// output in the result register. Throughput: one operation per cycle while
// the output is not stalled; the ALU logic between them is used once per item.
// A full result register that is not taken holds the input stage, and the
// input accepts again as soon as the result register can advance.
// Reset clears both valid bits; the payload registers are not reset.
module cpu_8bit_alu_with_flags
    import c8alu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cmd[4:0], operand_a[20:5], operand_b[36:21], bit_index[39:37],
    // zero_in[40], sub_in[41], half_in[42], carry_in[43], zero pad[47:44]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result[15:0], zero_out[16], sub_out[17], half_out[18], carry_out[19],
    // zero pad[23:20]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic              in_valid_reg;
    logic              in_valid_next;
    alu_req_t          in_req_reg;
    alu_req_t          in_req_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_result_reg;
    flags_t            out_flags_reg;

    logic              out_ready;
    logic              in_fire;
    logic              move;
    logic [WORD_W-1:0] core_result;
    flags_t            core_flags;

    // The result register can load when it is empty or being drained.
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign move          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_req_next.cmd         = s_axis_tdata[4:0];
        in_req_next.operand_a   = s_axis_tdata[20:5];
        in_req_next.operand_b   = s_axis_tdata[36:21];
        in_req_next.bit_index   = s_axis_tdata[39:37];
        in_req_next.flags.zero  = s_axis_tdata[40];
        in_req_next.flags.sub   = s_axis_tdata[41];
        in_req_next.flags.half  = s_axis_tdata[42];
        in_req_next.flags.carry = s_axis_tdata[43];
        in_valid_next  = in_fire || (in_valid_reg && !out_ready);
        out_valid_next = move || (out_valid_reg && !m_axis_tready);
    end

    c8alu_core u_core (
        .req    (in_req_reg),
        .result (core_result),
        .flags  (core_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_req_reg <= in_req_next;
        if (move)
        begin
            out_result_reg <= core_result;
            out_flags_reg  <= core_flags;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_flags_reg.carry, out_flags_reg.half,
                            out_flags_reg.sub, out_flags_reg.zero, out_result_reg};

    a_rise_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result became valid without a loaded input");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_ready) |=> out_valid_reg)
        else $error("input item was not moved into the result register");

    a_blocked_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    a_result_value: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> (out_result_reg == $past(core_result)
                  && out_flags_reg == $past(core_flags)))
        else $error("result register does not match the ALU output");

endmodule

FILE: design/c8alu_core.sv
// ----------------------------------------------------------------------------
// c8alu_core
// Combinational datapath: result and new flags for one operation.
// ----------------------------------------------------------------------------
module c8alu_core
    import c8alu_pkg::*;
(
    input  alu_req_t           req,
    output logic [WORD_W-1:0]  result,
    output flags_t             flags
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              cin_flag;
    logic              zin;
    logic              nin;
    logic              hin;

    // Shared 8-bit add/subtract.
    logic              as_sub;
    logic              as_cin;
    logic [BYTE_W-1:0] as_rhs;
    logic [BYTE_W:0]   as_full;
    logic [4:0]        as_nib;
    logic [BYTE_W-1:0] as_res;
    logic              as_half;
    logic              as_carry;

    // Shifts and rotates.
    shift_op_t         sh_op;
    logic [BYTE_W-1:0] sh_res;
    logic              sh_carry;

    // Decimal adjust.
    logic [BYTE_W-1:0] daa_adj;
    logic [BYTE_W-1:0] daa_res;
    logic              daa_carry;

    // 16-bit add.
    logic [WORD_W-1:0] w_rhs;
    logic [BYTE_W:0]   w_low;
    logic [4:0]        w_nib;
    logic [WORD_W:0]   w_full;

    logic [BYTE_W-1:0] bit_mask;
    logic [BYTE_W-1:0] r8;

    assign a        = req.operand_a[BYTE_W-1:0];
    assign b        = req.operand_b[BYTE_W-1:0];
    assign cin_flag = req.flags.carry;
    assign zin      = req.flags.zero;
    assign nin      = req.flags.sub;
    assign hin      = req.flags.half;
    assign bit_mask = BYTE_W'(1) << req.bit_index;

    always_comb
    begin
        as_sub = (req.cmd == OP_SUB) || (req.cmd == OP_SBC) || (req.cmd == OP_CP)
              || (req.cmd == OP_DEC);
        as_cin = ((req.cmd == OP_ADC) || (req.cmd == OP_SBC)) ? cin_flag : 1'b0;
        as_rhs = ((req.cmd == OP_INC) || (req.cmd == OP_DEC)) ? BYTE_W'(1) : b;
        if (as_sub)
        begin
            as_full = {1'b0, a} - {1'b0, as_rhs} - {{BYTE_W{1'b0}}, as_cin};
            as_nib  = {1'b0, a[3:0]} - {1'b0, as_rhs[3:0]} - {4'b0, as_cin};
        end
        else
        begin
            as_full = {1'b0, a} + {1'b0, as_rhs} + {{BYTE_W{1'b0}}, as_cin};
            as_nib  = {1'b0, a[3:0]} + {1'b0, as_rhs[3:0]} + {4'b0, as_cin};
        end
        // Bit 8 and bit 4 are the carry, or the borrow on subtraction.
        as_res   = as_full[BYTE_W-1:0];
        as_carry = as_full[BYTE_W];
        as_half  = as_nib[4];
    end

    always_comb
    begin
        if (req.cmd >= OP_RLCA)
            sh_op = shift_op_t'(3'(req.cmd - OP_RLCA));
        else
            sh_op = shift_op_t'(3'(req.cmd - OP_RLC));
        unique case (sh_op)
            SH_RLC:
            begin
                sh_res   = {a[6:0], a[7]};
                sh_carry = a[7];
            end
            SH_RRC:
            begin
                sh_res   = {a[0], a[7:1]};
                sh_carry = a[0];
            end
            SH_RL:
            begin
                sh_res   = {a[6:0], cin_flag};
                sh_carry = a[7];
            end
            SH_RR:
            begin
                sh_res   = {cin_flag, a[7:1]};
                sh_carry = a[0];
            end
            SH_SLA:
            begin
                sh_res   = {a[6:0], 1'b0};
                sh_carry = a[7];
            end
            SH_SRA:
            begin
                sh_res   = {a[7], a[7:1]};
                sh_carry = a[0];
            end
            SH_SWAP:
            begin
                sh_res   = {a[3:0], a[7:4]};
                sh_carry = 1'b0;
            end
            SH_SRL:
            begin
                sh_res   = {1'b0, a[7:1]};
                sh_carry = a[0];
            end
            default:
            begin
                sh_res   = a;
                sh_carry = cin_flag;
            end
        endcase
    end

    always_comb
    begin
        if (!nin)
        begin
            daa_carry = cin_flag || (a > DAA_HI_LIMIT);
            daa_adj   = (daa_carry ? DAA_HI_ADJ : 8'h00)
                      | ((hin || (a[3:0] > DAA_LO_LIMIT)) ? DAA_LO_ADJ : 8'h00);
            daa_res   = a + daa_adj;
        end
        else
        begin
            daa_carry = cin_flag;
            daa_adj   = (cin_flag ? DAA_HI_ADJ : 8'h00) | (hin ? DAA_LO_ADJ : 8'h00);
            daa_res   = a - daa_adj;
        end
    end

    always_comb
    begin
        if (req.cmd == OP_ADDSP)
            w_rhs = {{BYTE_W{b[BYTE_W-1]}}, b};
        else
            w_rhs = req.operand_b;
        w_low  = {1'b0, req.operand_a[7:0]} + {1'b0, w_rhs[7:0]};
        w_nib  = {1'b0, req.operand_a[11:8]} + {1'b0, w_rhs[11:8]}
               + {4'b0, w_low[BYTE_W]};
        w_full = {1'b0, req.operand_a} + {1'b0, w_rhs};
    end

    always_comb
    begin
        r8     = a;
        result = {{BYTE_W{1'b0}}, a};
        flags  = req.flags;
        unique case (req.cmd)
            OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP:
            begin
                r8          = (req.cmd == OP_CP) ? a : as_res;
                flags.zero  = (as_res == '0);
                flags.sub   = as_sub;
                flags.half  = as_half;
                flags.carry = as_carry;
            end
            OP_AND, OP_XOR, OP_OR:
            begin
                if (req.cmd == OP_AND)
                    r8 = a & b;
                else if (req.cmd == OP_XOR)
                    r8 = a ^ b;
                else
                    r8 = a | b;
                flags.zero  = (r8 == '0);
                flags.sub   = 1'b0;
                flags.half  = (req.cmd == OP_AND);
                flags.carry = 1'b0;
            end
            OP_INC, OP_DEC:
            begin
                r8         = as_res;
                flags.zero = (as_res == '0);
                flags.sub  = as_sub;
                flags.half = as_half;
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
            begin
                r8          = sh_res;
                // The accumulator forms always clear Z.
                flags.zero  = (req.cmd < OP_RLCA) && (sh_res == '0);
                flags.sub   = 1'b0;
                flags.half  = 1'b0;
                flags.carry = sh_carry;
            end
            OP_BIT:
            begin
                flags.zero = ~|(a & bit_mask);
                flags.sub  = 1'b0;
                flags.half = 1'b1;
            end
            OP_RES:
            begin
                r8 = a & ~bit_mask;
            end
            OP_SET:
            begin
                r8 = a | bit_mask;
            end
            OP_DAA:
            begin
                r8          = daa_res;
                flags.zero  = (daa_res == '0);
                flags.half  = 1'b0;
                flags.carry = daa_carry;
            end
            OP_CPL:
            begin
                r8         = ~a;
                flags.sub  = 1'b1;
                flags.half = 1'b1;
            end
            OP_SCF:
            begin
                flags.sub   = 1'b0;
                flags.half  = 1'b0;
                flags.carry = 1'b1;
            end
            OP_CCF:
            begin
                flags.sub   = 1'b0;
                flags.half  = 1'b0;
                flags.carry = ~cin_flag;
            end
            OP_ADD16, OP_ADDSP:
            begin
                flags.zero  = (req.cmd == OP_ADDSP) ? 1'b0 : zin;
                flags.sub   = 1'b0;
                flags.half  = w_nib[4];
                flags.carry = w_full[WORD_W];
            end
            default:
            begin
                // Unused code passes the full left operand and the flags through.
                r8 = a;
            end
        endcase

        if ((req.cmd == OP_ADD16) || (req.cmd == OP_ADDSP))
            result = w_full[WORD_W-1:0];
        else if (req.cmd > OP_ADDSP)
            result = req.operand_a;
        else
            result = {{BYTE_W{1'b0}}, r8};
    end

endmodule
